[rtl/rdwt_pkg.sv]
// Shared types, codes and constants of the reliable datagram window tracker.
package rdwt_pkg;

  localparam int unsigned NODES_DEF   = 4;
  localparam int unsigned WINDOW_DEF  = 16;
  localparam int unsigned CMD_DEPTH   = 2;
  localparam int unsigned OUT_DEPTH   = 4;
  localparam int unsigned AGE_W       = 20;
  localparam logic [AGE_W-1:0] AGE_MAX     = '1;
  localparam logic [AGE_W-1:0] RESEND_RST  = AGE_W'(1228);
  localparam logic [AGE_W-1:0] LINK_RST    = AGE_W'(4096 * 20);
  localparam int unsigned CFG_DATA_W  = AGE_W;

  typedef enum logic [1:0] {
    CFG_IS_HOST = 2'd0,
    CFG_RESEND  = 2'd1,
    CFG_LINK    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_RECEIVE = 3'd0,
    OP_SEND    = 3'd1,
    OP_TICK    = 3'd2,
    OP_OPEN    = 3'd3,
    OP_CLOSE   = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_PLAIN     = 2'd0,
    KIND_IMPORTANT = 2'd1,
    KIND_ACK       = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ACT_DROP       = 4'd0,
    ACT_DELIVER    = 4'd1,
    ACT_ACK        = 4'd2,
    ACT_TRANSMIT   = 4'd3,
    ACT_RETRANSMIT = 4'd4,
    ACT_CLOSED     = 4'd5,
    ACT_JOINED     = 4'd6,
    ACT_FULL       = 4'd7,
    ACT_NOT_OPEN   = 4'd8
  } action_e;

  typedef enum logic [2:0] {
    CLS_RX,
    CLS_SEND,
    CLS_TICK,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_BAD
  } cls_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RX_CHK,
    ST_RX_DLV,
    ST_T_PEER,
    ST_T_SLOT,
    ST_T_AGE,
    ST_T_LINK,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  node;
    logic [31:0] sender_id;
    logic [7:0]  seq;
    logic [1:0]  kind;
    logic [15:0] packet_type;
    logic        important;
    logic [15:0] elapsed;
    logic [7:0]  reason;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  action;
    logic [7:0]  peer;
    logic [7:0]  slot;
    logic [15:0] out_type;
    logic [7:0]  close_reason;
    logic        last;
  } out_item_t;

  typedef struct packed {
    cls_e     cls;
    logic     node_bad;
    in_item_t item;
  } cmd_t;

  typedef struct packed {
    logic             is_host;
    logic [AGE_W-1:0] resend_timeout;
    logic [AGE_W-1:0] link_timeout;
  } cfg_t;

endpackage

[rtl/reliable_datagram_window_tracker.sv]
// Top level: per-peer selective-repeat window tracker with queue ports.
// Flow: a word passes the command queue, the sequencer takes it and runs it,
//   and at its end the held last result enters the result queue; each in-order
//   delivery adds a check and a deliver step, and a tick walks every open peer
//   over half a window of slots, ages each pending slot, then checks its link.
// Sequencer: one word at a time, and it freezes while the result queue is full.
// Reset (async, active low): peers closed, windows and link timers cleared, queues
//   emptied, registers to defaults; stored peer ids, held types and slot ages undefined.
module reliable_datagram_window_tracker import rdwt_pkg::*; #(
  parameter int unsigned NODES  = NODES_DEF,
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  in_item_t              in_item_i,
  output logic                  full,
  input  logic                  pop,
  output out_item_t             out_item_o,
  output logic                  empty,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg_q;
  cmd_t      cmd;
  logic      cmd_valid, cmd_pop;
  logic      res_push, res_full;
  out_item_t res_item;

  // Configuration registers; writes must arrive only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.is_host        <= 1'b1;
      cfg_q.resend_timeout <= RESEND_RST;
      cfg_q.link_timeout   <= LINK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IS_HOST: cfg_q.is_host        <= cfg_data_i[0];
        CFG_RESEND:  cfg_q.resend_timeout <= cfg_data_i;
        CFG_LINK:    cfg_q.link_timeout   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Front: take the word, classify operation and node validity.
  rdwt_front #(.NODES(NODES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .push_i      (push),
    .in_item_i   (in_item_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid)
  );

  // Back: walk the windows and timers, hold the newest result until the
  // next one (or the end of the command) tells whether it is the last.
  rdwt_back #(.NODES(NODES), .WINDOW(WINDOW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (res_full),
    .out_push_o  (res_push),
    .out_item_o  (res_item)
  );

  // Result queue decouples the sequencer from the consumer.
  rdwt_fifo #(.T(out_item_t), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule

[rtl/rdwt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rdwt_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/rdwt_fifo.sv]
// Small register FIFO for any packed word type.
module rdwt_fifo #(
  parameter type         T     = logic [7:0],
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[rtl/rdwt_front.sv]
// Front end: accept input words, classify operation and node, queue commands.
module rdwt_front import rdwt_pkg::*; #(
  parameter int unsigned NODES = NODES_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     push_i,
  input  in_item_t in_item_i,
  output logic     full_o,
  input  logic     cmd_pop_i,
  output cmd_t     cmd_o,
  output logic     cmd_valid_o
);

  cmd_t cmd_in;
  logic cmd_empty;

  always_comb begin
    cmd_in.item     = in_item_i;
    cmd_in.node_bad = (in_item_i.node >= 8'(NODES)) ||
                      (cfg_i.is_host && (in_item_i.node == '0));
    unique case (in_item_i.operation)
      OP_RECEIVE: cmd_in.cls = CLS_RX;
      OP_SEND:    cmd_in.cls = CLS_SEND;
      OP_TICK:    cmd_in.cls = CLS_TICK;
      OP_OPEN:    cmd_in.cls = CLS_OPEN;
      OP_CLOSE:   cmd_in.cls = CLS_CLOSE;
      default:    cmd_in.cls = CLS_BAD;
    endcase
  end

  rdwt_fifo #(.T(cmd_t), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

[rtl/rdwt_back.sv]
// Back end: sequencer that carries out one command against the peer windows.
module rdwt_back import rdwt_pkg::*; #(
  parameter int unsigned NODES  = NODES_DEF,
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      out_full_i,
  output logic      out_push_o,
  output out_item_t out_item_o
);

  localparam int unsigned NW   = $clog2(NODES);
  localparam int unsigned SW   = $clog2(WINDOW);
  localparam int unsigned HALF = WINDOW / 2;
  localparam int unsigned HW   = $clog2(HALF);
  localparam int unsigned AW   = NW + SW;
  localparam int unsigned RAMD = NODES * (2 ** SW);

  state_e              st_q, st_d;
  cmd_t                cmd_q, cmd_d;
  logic [NW-1:0]       n_q, n_d;
  logic [HW-1:0]       k_q, k_d;
  logic                hold_v_q, hold_v_d;
  out_item_t           hold_q, hold_d;

  logic                open_q [NODES];
  logic                open_d [NODES];
  logic [31:0]         id_q   [NODES];
  logic [31:0]         id_d   [NODES];
  logic [SW-1:0]       spos_q [NODES];
  logic [SW-1:0]       spos_d [NODES];
  logic [SW-1:0]       rpos_q [NODES];
  logic [SW-1:0]       rpos_d [NODES];
  logic [AGE_W-1:0]    link_q [NODES];
  logic [AGE_W-1:0]    link_d [NODES];
  logic [WINDOW-1:0]   pend_q [NODES];
  logic [WINDOW-1:0]   pend_d [NODES];
  logic [WINDOW-1:0]   held_q [NODES];
  logic [WINDOW-1:0]   held_d [NODES];

  logic                emit_v;
  out_item_t           emit_w;

  logic                ty_we, ty_re, ag_we, ag_re;
  logic [AW-1:0]       ty_waddr, ty_raddr, ag_waddr, ag_raddr;
  logic [15:0]         ty_rdata;
  logic [AGE_W-1:0]    ag_wdata, ag_rdata;

  logic [NW-1:0]       nidx;
  logic [SW-1:0]       sq, tx_p, rx_p, t_s;
  logic [AGE_W:0]      ag_sum, lk_sum;
  logic [AGE_W-1:0]    ag_new, lk_new;

  function automatic logic [SW-1:0] f_inc(input logic [SW-1:0] p);
    return (p == SW'(WINDOW - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SW-1:0] f_back(input logic [SW-1:0] p);
    return (p >= SW'(HALF)) ? p - SW'(HALF) : p + SW'(WINDOW - HALF);
  endfunction

  function automatic logic [SW-1:0] f_tslot(input logic [SW-1:0] p,
                                            input logic [HW-1:0] k);
    logic [SW:0] t;
    t = {1'b0, f_back(p)} + (SW + 1)'(k);
    return (t >= (SW + 1)'(WINDOW)) ? SW'(t - (SW + 1)'(WINDOW)) : t[SW-1:0];
  endfunction

  function automatic out_item_t f_res(input action_e a, input logic [7:0] peer,
                                      input logic [7:0] slot,
                                      input logic [15:0] ty,
                                      input logic [7:0] rsn);
    out_item_t r;
    r.action       = a;
    r.peer         = peer;
    r.slot         = slot;
    r.out_type     = ty;
    r.close_reason = rsn;
    r.last         = 1'b0;
    return r;
  endfunction

  assign nidx   = cmd_q.item.node[NW-1:0];
  assign sq     = cmd_q.item.seq[SW-1:0];
  assign tx_p   = spos_q[nidx];
  assign rx_p   = rpos_q[n_q];
  assign t_s    = f_tslot(spos_q[n_q], k_q);
  assign ag_sum = {1'b0, ag_rdata} + (AGE_W + 1)'(cmd_q.item.elapsed);
  assign ag_new = (ag_sum > {1'b0, AGE_MAX}) ? AGE_MAX : ag_sum[AGE_W-1:0];
  assign lk_sum = {1'b0, link_q[n_q]} + (AGE_W + 1)'(cmd_q.item.elapsed);
  assign lk_new = (lk_sum > {1'b0, AGE_MAX}) ? AGE_MAX : lk_sum[AGE_W-1:0];

  always_comb begin
    st_d       = st_q;
    cmd_d      = cmd_q;
    n_d        = n_q;
    k_d        = k_q;
    hold_v_d   = hold_v_q;
    hold_d     = hold_q;
    open_d     = open_q;
    id_d       = id_q;
    spos_d     = spos_q;
    rpos_d     = rpos_q;
    link_d     = link_q;
    pend_d     = pend_q;
    held_d     = held_q;
    emit_v     = 1'b0;
    emit_w     = f_res(ACT_DROP, '0, '0, '0, '0);
    cmd_pop_o  = 1'b0;
    out_push_o = 1'b0;
    out_item_o = hold_q;
    ty_we      = 1'b0;
    ty_re      = 1'b0;
    ty_waddr   = {nidx, sq};
    ty_raddr   = {n_q, rx_p};
    ag_we      = 1'b0;
    ag_re      = 1'b0;
    ag_waddr   = {n_q, t_s};
    ag_raddr   = {n_q, t_s};
    ag_wdata   = ag_new;

    // Freeze everything while the result queue has no room.
    if (!out_full_i) begin
      unique case (st_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            cmd_pop_o = 1'b1;
            cmd_d     = cmd_i;
            n_d       = '0;
            k_d       = '0;
            st_d      = ST_EXEC;
          end
        end
        ST_EXEC: begin
          st_d = ST_FIN;
          n_d  = nidx;
          unique case (cmd_q.cls)
            CLS_RX: begin
              if (cmd_q.node_bad || !open_q[nidx] ||
                  (id_q[nidx] != cmd_q.item.sender_id)) begin
                emit_v = 1'b1;
                emit_w = f_res(ACT_DROP, cmd_q.item.node, '0, '0, '0);
              end else begin
                link_d[nidx] = '0;
                if (cmd_q.item.kind == KIND_PLAIN) begin
                  emit_v = 1'b1;
                  emit_w = f_res(ACT_DELIVER, cmd_q.item.node, '0,
                                 cmd_q.item.packet_type, '0);
                end else if (cmd_q.item.seq >= 8'(WINDOW)) begin
                  open_d[nidx] = 1'b0;
                  pend_d[nidx] = '0;
                  held_d[nidx] = '0;
                  spos_d[nidx] = '0;
                  rpos_d[nidx] = '0;
                  emit_v       = 1'b1;
                  emit_w       = f_res(ACT_CLOSED, cmd_q.item.node, '0, '0, '0);
                end else if (cmd_q.item.kind == KIND_ACK) begin
                  pend_d[nidx][sq] = 1'b0;
                end else if (cmd_q.item.kind != KIND_IMPORTANT) begin
                  emit_v = 1'b1;
                  emit_w = f_res(ACT_DROP, cmd_q.item.node, '0, '0, '0);
                end else begin
                  // Keep the first copy of a slot that is already held.
                  if (!held_q[nidx][sq]) begin
                    held_d[nidx][sq] = 1'b1;
                    ty_we            = 1'b1;
                  end
                  emit_v = 1'b1;
                  emit_w = f_res(ACT_ACK, cmd_q.item.node, 8'(sq), '0, '0);
                  st_d   = ST_RX_CHK;
                end
              end
            end
            CLS_SEND: begin
              if (cmd_q.node_bad || !open_q[nidx]) begin
                emit_v = 1'b1;
                emit_w = f_res(ACT_NOT_OPEN, cmd_q.item.node, '0, '0, '0);
              end else if (!cmd_q.item.important) begin
                emit_v = 1'b1;
                emit_w = f_res(ACT_TRANSMIT, cmd_q.item.node, '0,
                               cmd_q.item.packet_type, '0);
              end else if (pend_q[nidx][f_back(tx_p)]) begin
                open_d[nidx] = 1'b0;
                pend_d[nidx] = '0;
                held_d[nidx] = '0;
                spos_d[nidx] = '0;
                rpos_d[nidx] = '0;
                link_d[nidx] = '0;
                emit_v       = 1'b1;
                emit_w       = f_res(ACT_CLOSED, cmd_q.item.node, '0, '0, '0);
              end else begin
                pend_d[nidx][tx_p] = 1'b1;
                spos_d[nidx]       = f_inc(tx_p);
                ag_we              = 1'b1;
                ag_waddr           = {nidx, tx_p};
                ag_wdata           = '0;
                emit_v             = 1'b1;
                emit_w             = f_res(ACT_TRANSMIT, cmd_q.item.node, 8'(tx_p),
                                           cmd_q.item.packet_type, '0);
              end
            end
            CLS_TICK: begin
              n_d  = '0;
              st_d = ST_T_PEER;
            end
            CLS_OPEN: begin
              emit_v = 1'b1;
              if (cmd_q.node_bad) begin
                emit_w = f_res(ACT_DROP, cmd_q.item.node, '0, '0, '0);
              end else if (open_q[nidx]) begin
                emit_w = f_res(ACT_FULL, cmd_q.item.node, '0, '0, '0);
              end else begin
                open_d[nidx] = 1'b1;
                id_d[nidx]   = cmd_q.item.sender_id;
                pend_d[nidx] = '0;
                held_d[nidx] = '0;
                spos_d[nidx] = '0;
                rpos_d[nidx] = '0;
                link_d[nidx] = '0;
                emit_w       = f_res(ACT_JOINED, cmd_q.item.node, '0, '0, '0);
              end
            end
            CLS_CLOSE: begin
              emit_v = 1'b1;
              if (cmd_q.node_bad || !open_q[nidx]) begin
                emit_w = f_res(ACT_NOT_OPEN, cmd_q.item.node, '0, '0, '0);
              end else begin
                open_d[nidx] = 1'b0;
                pend_d[nidx] = '0;
                held_d[nidx] = '0;
                spos_d[nidx] = '0;
                rpos_d[nidx] = '0;
                link_d[nidx] = '0;
                emit_w       = f_res(ACT_CLOSED, cmd_q.item.node, '0, '0,
                                     cmd_q.item.reason);
              end
            end
            default: begin
              emit_v = 1'b1;
              emit_w = f_res(ACT_DROP, cmd_q.item.node, '0, '0, '0);
            end
          endcase
        end
        ST_RX_CHK: begin
          if (held_q[n_q][rx_p]) begin
            ty_re = 1'b1;
            st_d  = ST_RX_DLV;
          end else begin
            st_d = ST_FIN;
          end
        end
        ST_RX_DLV: begin
          // Deliver in order and release the slot half a window back.
          held_d[n_q][f_back(rx_p)] = 1'b0;
          rpos_d[n_q]               = f_inc(rx_p);
          emit_v                    = 1'b1;
          emit_w                    = f_res(ACT_DELIVER, 8'(n_q), 8'(rx_p),
                                            ty_rdata, '0);
          st_d                      = ST_RX_CHK;
        end
        ST_T_PEER: begin
          k_d = '0;
          if (open_q[n_q] && !(cfg_i.is_host && (n_q == '0))) begin
            st_d = ST_T_SLOT;
          end else if (n_q == NW'(NODES - 1)) begin
            st_d = ST_FIN;
          end else begin
            n_d = n_q + 1'b1;
          end
        end
        ST_T_SLOT: begin
          if (pend_q[n_q][t_s]) begin
            ag_re = 1'b1;
            st_d  = ST_T_AGE;
          end else if (k_q == HW'(HALF - 1)) begin
            st_d = ST_T_LINK;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
        ST_T_AGE: begin
          ag_we = 1'b1;
          if (ag_new > cfg_i.resend_timeout) begin
            ag_wdata = '0;
            emit_v   = 1'b1;
            emit_w   = f_res(ACT_RETRANSMIT, 8'(n_q), 8'(t_s), '0, '0);
          end
          if (k_q == HW'(HALF - 1)) begin
            st_d = ST_T_LINK;
          end else begin
            k_d  = k_q + 1'b1;
            st_d = ST_T_SLOT;
          end
        end
        ST_T_LINK: begin
          if (lk_new >= cfg_i.link_timeout) begin
            open_d[n_q] = 1'b0;
            pend_d[n_q] = '0;
            held_d[n_q] = '0;
            spos_d[n_q] = '0;
            rpos_d[n_q] = '0;
            link_d[n_q] = '0;
            emit_v      = 1'b1;
            emit_w      = f_res(ACT_CLOSED, 8'(n_q), '0, '0, '0);
          end else begin
            link_d[n_q] = lk_new;
          end
          if (n_q == NW'(NODES - 1)) begin
            st_d = ST_FIN;
          end else begin
            n_d  = n_q + 1'b1;
            st_d = ST_T_PEER;
          end
        end
        ST_FIN: begin
          // Flush the held result as the final one of this command.
          if (hold_v_q) begin
            out_push_o      = 1'b1;
            out_item_o.last = 1'b1;
            hold_v_d        = 1'b0;
          end
          st_d = ST_IDLE;
        end
        default: st_d = ST_IDLE;
      endcase

      // A new result pushes out the one held before it.
      if (emit_v) begin
        if (hold_v_q) begin
          out_push_o = 1'b1;
        end
        hold_d   = emit_w;
        hold_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      hold_v_q <= 1'b0;
      for (int i = 0; i < NODES; i++) begin
        open_q[i] <= 1'b0;
        spos_q[i] <= '0;
        rpos_q[i] <= '0;
        link_q[i] <= '0;
        pend_q[i] <= '0;
        held_q[i] <= '0;
      end
    end else begin
      st_q     <= st_d;
      hold_v_q <= hold_v_d;
      open_q   <= open_d;
      spos_q   <= spos_d;
      rpos_q   <= rpos_d;
      link_q   <= link_d;
      pend_q   <= pend_d;
      held_q   <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    n_q    <= n_d;
    k_q    <= k_d;
    hold_q <= hold_d;
    id_q   <= id_d;
  end

  rdwt_ram #(.WIDTH(16), .DEPTH(RAMD)) u_type_ram (
    .clk_i   (clk_i),
    .we_i    (ty_we),
    .waddr_i (ty_waddr),
    .wdata_i (cmd_q.item.packet_type),
    .re_i    (ty_re),
    .raddr_i (ty_raddr),
    .rdata_o (ty_rdata)
  );

  rdwt_ram #(.WIDTH(AGE_W), .DEPTH(RAMD)) u_age_ram (
    .clk_i   (clk_i),
    .we_i    (ag_we),
    .waddr_i (ag_waddr),
    .wdata_i (ag_wdata),
    .re_i    (ag_re),
    .raddr_i (ag_raddr),
    .rdata_o (ag_rdata)
  );

  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !hold_v_q)
    else $error("result held while idle");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push_o |-> !out_full_i)
    else $error("result pushed into full queue");

  a_drain_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_RX_DLV) |-> open_q[n_q])
    else $error("delivery drain on closed peer");

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FIN && !out_full_i) |=> (st_q == ST_IDLE && !hold_v_q))
    else $error("command did not retire");

endmodule
